// ----- hdl/lbps_pkg.sv -----
// Shared types and constants for the LED blink pattern sequencer.
package lbps_pkg;

  // Request codes carried by the input channel.
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SET  = 2'd1,
    REQ_STOP = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  // Display modes.
  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_SCHEDULE = 3'd1,
    MODE_TRACE    = 3'd2,
    MODE_LOCK     = 3'd3,
    MODE_OPEN     = 3'd4
  } mode_t;

  // LED drive codes.
  typedef enum logic [1:0] {
    COLOR_OFF   = 2'd0,
    COLOR_RED   = 2'd1,
    COLOR_BLUE  = 2'd2,
    COLOR_GREEN = 2'd3
  } color_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCHEDULE = 2'd0;
  localparam logic [1:0] CFG_TRACE    = 2'd1;
  localparam logic [1:0] CFG_LOCK     = 2'd2;
  localparam logic [1:0] CFG_OPEN     = 2'd3;

  // Reset values of the half-period registers.
  localparam logic [7:0] SCHEDULE_HP_RST = 8'd200;
  localparam logic [7:0] TRACE_HP_RST    = 8'd100;
  localparam logic [7:0] LOCK_HP_RST     = 8'd50;
  localparam logic [7:0] OPEN_HP_RST     = 8'd50;

  // Step positions that matter in the schedule and trace patterns.
  localparam logic [1:0] SCHED_STEP_OFF   = 2'd1;
  localparam logic [1:0] SCHED_STEP_RED   = 2'd0;
  localparam logic [2:0] TRACE_STEP_OFF_A = 3'd1;
  localparam logic [2:0] TRACE_STEP_ON_A  = 3'd2;
  localparam logic [2:0] TRACE_STEP_OFF_B = 3'd3;
  localparam logic [2:0] TRACE_STEP_ON_B  = 3'd4;
  localparam logic [2:0] TRACE_STEP_END   = 3'd5;

  // Half-period configuration as one group.
  typedef struct packed {
    logic [7:0] schedule_hp;
    logic [7:0] trace_hp;
    logic [7:0] lock_hp;
    logic [7:0] open_hp;
  } cfg_t;

  // Sequencer state.
  typedef struct packed {
    mode_t      mode;
    logic       cycle_on;
    logic [7:0] tick_count;
    logic [1:0] sched_step;
    logic [2:0] trace_step;
    color_t     color;
  } state_t;

endpackage

// ----- hdl/lbps_step.sv -----
// Next-state logic of the sequencer for one request.
module lbps_step (
  input  lbps_pkg::state_t cur,
  input  lbps_pkg::cfg_t   cfg,
  input  logic [1:0]       req_type,
  input  logic [2:0]       mode,
  output lbps_pkg::state_t nxt
);
  import lbps_pkg::*;

  logic [7:0] threshold;
  logic [7:0] count_inc;
  logic [1:0] sched_inc;
  logic [2:0] trace_inc;

  // Half-period of the current mode; off mode uses zero.
  always_comb begin
    case (cur.mode)
      MODE_SCHEDULE: threshold = cfg.schedule_hp;
      MODE_TRACE:    threshold = cfg.trace_hp;
      MODE_LOCK:     threshold = cfg.lock_hp;
      MODE_OPEN:     threshold = cfg.open_hp;
      default:       threshold = 8'd0;
    endcase
  end

  assign count_inc = cur.tick_count + 8'd1;
  assign sched_inc = cur.sched_step + 2'd1;
  assign trace_inc = cur.trace_step + 3'd1;

  // Apply the request to the state.
  always_comb begin
    nxt = cur;
    case (req_t'(req_type))
      REQ_TICK: begin
        if (cur.cycle_on) begin
          if (count_inc >= threshold) begin
            nxt.tick_count = 8'd0;
            // The pattern advances one half-period.
            case (cur.mode)
              MODE_SCHEDULE: begin
                nxt.sched_step = sched_inc;
                if (sched_inc == SCHED_STEP_OFF) begin
                  nxt.color = COLOR_OFF;
                end else if (sched_inc == SCHED_STEP_RED) begin
                  nxt.color = COLOR_RED;
                end
              end
              MODE_TRACE: begin
                nxt.trace_step = trace_inc;
                if (trace_inc == TRACE_STEP_OFF_A || trace_inc == TRACE_STEP_OFF_B) begin
                  nxt.color = COLOR_OFF;
                end else if (trace_inc == TRACE_STEP_ON_A ||
                             trace_inc == TRACE_STEP_ON_B) begin
                  nxt.color = COLOR_BLUE;
                end else if (trace_inc == TRACE_STEP_END) begin
                  nxt.trace_step = 3'd0;
                  nxt.cycle_on   = 1'b0;
                  nxt.color      = COLOR_OFF;
                  nxt.mode       = MODE_OFF;
                end
              end
              MODE_LOCK, MODE_OPEN: begin
                nxt.cycle_on = 1'b0;
                nxt.color    = COLOR_OFF;
                nxt.mode     = MODE_OFF;
              end
              default: begin
                nxt.tick_count = 8'd0;
              end
            endcase
          end else begin
            nxt.tick_count = count_inc;
          end
        end else begin
          nxt.tick_count = 8'd0;
        end
      end
      REQ_SET: begin
        // Modes above open are ignored.
        if (mode <= MODE_OPEN) begin
          nxt.mode       = mode_t'(mode);
          nxt.tick_count = 8'd0;
          case (mode_t'(mode))
            MODE_SCHEDULE: begin
              nxt.cycle_on   = 1'b1;
              nxt.sched_step = 2'd0;
              nxt.color      = COLOR_RED;
            end
            MODE_TRACE: begin
              nxt.cycle_on   = 1'b1;
              nxt.trace_step = 3'd0;
              nxt.color      = COLOR_BLUE;
            end
            MODE_LOCK: begin
              nxt.cycle_on = 1'b1;
              nxt.color    = COLOR_BLUE;
            end
            MODE_OPEN: begin
              nxt.cycle_on = 1'b1;
              nxt.color    = COLOR_GREEN;
            end
            default: begin
              nxt.color = COLOR_OFF;
            end
          endcase
        end
      end
      REQ_STOP: begin
        nxt.cycle_on = 1'b0;
        nxt.color    = COLOR_OFF;
        nxt.mode     = MODE_OFF;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// ----- hdl/led_blink_pattern_sequencer.sv -----
// Top level of the LED blink pattern sequencer.
//
// Usage: each request on the in_ channel is a tick (advance the half-period
// counter), a display-mode change, a stop or a no-op. Every request
// produces exactly one result on the out_ channel: the LED color, the
// display mode and the blinking flag as they stand after that request.
// The four half-period registers are written through the cfg_ port, one
// register per cycle with cfg_we high, and should only change while no
// request is in flight.
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle, limited only by the single output
// register; in_ready stays high while that register is empty or being read.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until out_ready returns, so the state never runs ahead.
// Reset (rst_n low, synchronous) sets the mode off, the LED off, the
// counters to zero and the half-periods to 200, 100, 50 and 50 ticks.
module led_blink_pattern_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [2:0] in_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_led_color,
  output logic [2:0] out_mode_now,
  output logic       out_blinking,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);
  import lbps_pkg::*;

  cfg_t   cfg_r;
  state_t state_r;
  state_t state_nxt;
  logic   in_fire;
  logic   out_valid_r;
  logic [1:0] out_color_r;
  logic [2:0] out_mode_r;
  logic   out_blink_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Half-period registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.schedule_hp <= SCHEDULE_HP_RST;
      cfg_r.trace_hp    <= TRACE_HP_RST;
      cfg_r.lock_hp     <= LOCK_HP_RST;
      cfg_r.open_hp     <= OPEN_HP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SCHEDULE: cfg_r.schedule_hp <= cfg_wdata;
        CFG_TRACE:    cfg_r.trace_hp    <= cfg_wdata;
        CFG_LOCK:     cfg_r.lock_hp     <= cfg_wdata;
        CFG_OPEN:     cfg_r.open_hp     <= cfg_wdata;
        default:      cfg_r.open_hp     <= cfg_r.open_hp;
      endcase
    end
  end

  // Next state for the request at the input.
  lbps_step u_step (
    .cur      (state_r),
    .cfg      (cfg_r),
    .req_type (in_req_type),
    .mode     (in_mode),
    .nxt      (state_nxt)
  );

  // Sequencer state advances on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode       <= MODE_OFF;
      state_r.cycle_on   <= 1'b0;
      state_r.tick_count <= 8'd0;
      state_r.sched_step <= 2'd0;
      state_r.trace_step <= 3'd0;
      state_r.color      <= COLOR_OFF;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_color_r <= state_nxt.color;
      out_mode_r  <= state_nxt.mode;
      out_blink_r <= state_nxt.cycle_on;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_color = out_color_r;
  assign out_mode_now  = out_mode_r;
  assign out_blinking  = out_blink_r;

endmodule

// ----- hdl/lbps_chk.sv -----
// Port-level checker for the LED blink pattern sequencer and its bind.
module lbps_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_led_color,
  input logic [2:0] out_mode_now,
  input logic       out_blinking
);
  import lbps_pkg::*;

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_led_color) &&
      $stable(out_mode_now) && $stable(out_blinking))
    else $error("stalled result changed");

  // With no result waiting, a request is always taken.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A stop request yields an idle, dark result in the next cycle.
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == REQ_STOP |=>
      out_valid && out_mode_now == MODE_OFF && out_led_color == COLOR_OFF &&
      !out_blinking)
    else $error("stop request did not go idle");

  // Off mode never lights the LED.
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_now == MODE_OFF |-> out_led_color == COLOR_OFF)
    else $error("LED lit in off mode");

  // Red belongs to schedule mode and green to open mode only.
  a_color_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_led_color != COLOR_RED || out_mode_now == MODE_SCHEDULE) &&
      (out_led_color != COLOR_GREEN || out_mode_now == MODE_OPEN))
    else $error("LED color does not match display mode");

endmodule

bind led_blink_pattern_sequencer lbps_chk u_lbps_chk (.*);
